FILE: sv/u8enc_pkg.sv
// ----------------------------------------------------------------------------
// u8enc_pkg
// Shared types and constants for the UTF-8 code point encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8enc_pkg;

	// Configuration register indexes
	localparam logic REG_CODE_LIMIT  = 1'b0;
	localparam logic REG_REPLACEMENT = 1'b1;

	// Reset values of the configuration registers
	localparam logic [31:0] CODE_LIMIT_RESET  = 32'h8000_0000;
	localparam logic [30:0] REPLACEMENT_RESET = 31'h0000_FFFD;

	// Length breakpoints of the six-byte form
	localparam logic [30:0] BREAK_2 = 31'h0000_0080;
	localparam logic [30:0] BREAK_3 = 31'h0000_0800;
	localparam logic [30:0] BREAK_4 = 31'h0001_0000;
	localparam logic [30:0] BREAK_5 = 31'h0020_0000;
	localparam logic [30:0] BREAK_6 = 31'h0400_0000;

	// Lead byte prefixes
	localparam logic [7:0] LEAD_2 = 8'hC0;
	localparam logic [7:0] LEAD_3 = 8'hE0;
	localparam logic [7:0] LEAD_4 = 8'hF0;
	localparam logic [7:0] LEAD_5 = 8'hF8;
	localparam logic [7:0] LEAD_6 = 8'hFC;
	localparam logic [1:0] CONT_PREFIX = 2'b10;

	// One classified code point waiting for serialization
	typedef struct packed {
		logic [30:0] code;    // after range replacement, always below 2^31
		logic [2:0]  nbytes;  // 1..6
	} entry_t;

	// Number of bytes in the encoding of a code point
	function automatic logic [2:0] byte_count(input logic [30:0] code);
		logic [2:0] n;
		if (code < BREAK_2)      n = 3'd1;
		else if (code < BREAK_3) n = 3'd2;
		else if (code < BREAK_4) n = 3'd3;
		else if (code < BREAK_5) n = 3'd4;
		else if (code < BREAK_6) n = 3'd5;
		else                     n = 3'd6;
		return n;
	endfunction

endpackage

`default_nettype wire

FILE: sv/u8enc_front.sv
// ----------------------------------------------------------------------------
// u8enc_front
// Holds the configuration registers, replaces out-of-range code points and
// classifies each accepted code point by its encoded length.
// ----------------------------------------------------------------------------
`default_nettype none

module u8enc_front (
	input  wire                    clk,
	input  wire                    arst_n,
	// configuration write channel
	input  wire                    cfg_valid,
	input  wire                    cfg_index,
	input  wire [31:0]             cfg_data,
	// classified code point toward the queue
	input  wire  [31:0]            code_point,
	output u8enc_pkg::entry_t      entry
);

	logic [31:0] code_limit_q;
	logic [30:0] replacement_q;
	logic        replace;
	logic [30:0] code_sel;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_limit_q  <= u8enc_pkg::CODE_LIMIT_RESET;
			replacement_q <= u8enc_pkg::REPLACEMENT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				u8enc_pkg::REG_CODE_LIMIT:  code_limit_q  <= cfg_data;
				u8enc_pkg::REG_REPLACEMENT: replacement_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Range check: a limit above 2^31 acts as 2^31, so bit 31 always replaces
	always_comb begin
		replace  = (code_point >= code_limit_q) || code_point[31];
		code_sel = replace ? replacement_q : code_point[30:0];
	end

	// Classification
	always_comb begin
		entry.code   = code_sel;
		entry.nbytes = u8enc_pkg::byte_count(code_sel);
	end

endmodule

`default_nettype wire

FILE: sv/u8enc_queue.sv
// ----------------------------------------------------------------------------
// u8enc_queue
// Short FIFO of classified code points between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module u8enc_queue #(
	parameter int DEPTH = 2
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push,
	input  u8enc_pkg::entry_t      push_entry,
	input  wire                    pop,
	output u8enc_pkg::entry_t      head,
	output logic                   not_empty,
	output logic                   full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	u8enc_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == FULL_CNT);

endmodule

`default_nettype wire

FILE: sv/u8enc_back.sv
// ----------------------------------------------------------------------------
// u8enc_back
// Serializes the queue head into UTF-8 bytes, one per cycle while byte_stall is low,
// through an output register; pops the entry when its last byte is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module u8enc_back (
	input  wire                    clk,
	input  wire                    arst_n,
	input  u8enc_pkg::entry_t      head,
	input  wire                    not_empty,
	output logic                   pop,
	output logic                   byte_valid,
	input  wire                    byte_stall,
	output logic [7:0]             out_byte,
	output logic                   last_byte
);

	logic        byte_valid_q;
	logic [7:0]  out_byte_q;
	logic        last_byte_q;
	logic [2:0]  idx_q;        // byte position within the current sequence
	logic        advance;
	logic        emit;
	logic [2:0]  rem;          // bytes still following this one
	logic        is_last;
	logic [30:0] part;
	logic [7:0]  lead;
	logic [7:0]  byte_nxt;

	assign advance = !byte_valid_q || !byte_stall;
	assign emit    = advance && not_empty;
	assign pop     = emit && is_last;

	// Byte selection for the current position
	always_comb begin
		rem     = head.nbytes - 3'd1 - idx_q;
		is_last = (rem == 3'd0);
		case (rem)
			3'd0:    part = head.code;
			3'd1:    part = head.code >> 6;
			3'd2:    part = head.code >> 12;
			3'd3:    part = head.code >> 18;
			3'd4:    part = head.code >> 24;
			3'd5:    part = head.code >> 30;
			default: part = head.code;
		endcase
		case (head.nbytes)
			3'd2:    lead = u8enc_pkg::LEAD_2;
			3'd3:    lead = u8enc_pkg::LEAD_3;
			3'd4:    lead = u8enc_pkg::LEAD_4;
			3'd5:    lead = u8enc_pkg::LEAD_5;
			3'd6:    lead = u8enc_pkg::LEAD_6;
			default: lead = 8'h00;
		endcase
		if (idx_q != 3'd0) begin
			byte_nxt = {u8enc_pkg::CONT_PREFIX, part[5:0]};
		end else if (head.nbytes == 3'd1) begin
			byte_nxt = {1'b0, part[6:0]};
		end else begin
			byte_nxt = lead | part[7:0];
		end
	end

	// Position counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			byte_valid_q <= 1'b0;
		end else if (advance) begin
			byte_valid_q <= not_empty;
			if (emit) begin
				idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q  <= byte_nxt;
			last_byte_q <= is_last;
		end
	end

	assign byte_valid = byte_valid_q;
	assign out_byte   = out_byte_q;
	assign last_byte  = last_byte_q;

endmodule

`default_nettype wire

FILE: sv/utf8_codepoint_encoder_core.sv
// ----------------------------------------------------------------------------
// utf8_codepoint_encoder_core
// Encodes 32-bit code points into 1..6-byte UTF-8 sequences, one byte per
// output transaction, with out-of-range code points replaced.
// Path: the code point is written into the queue, then its first byte is loaded
// into the output register. Throughput: one byte per cycle while byte_stall is low,
// set by the single-byte output register of the serializer.
// A code point is accepted every cycle while the QUEUE_DEPTH-entry queue has room.
// Reset: asynchronous, clears queue and output valid; registers take defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_codepoint_encoder_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire         clk,
	input  wire         arst_n,
	// configuration write channel
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         cfg_index,
	input  wire  [31:0] cfg_data,
	// code point channel
	input  wire         code_valid,
	output logic        code_stall,
	input  wire  [31:0] code_point,
	// byte channel
	output logic        byte_valid,
	input  wire         byte_stall,
	output logic [7:0]  out_byte,
	output logic        last_byte
);

	u8enc_pkg::entry_t entry;
	u8enc_pkg::entry_t head;
	logic              push;
	logic              pop;
	logic              not_empty;
	logic              full;

	assign cfg_ready  = 1'b1;
	assign code_stall = full;
	assign push       = code_valid && !full;

	u8enc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.code_point (code_point),
		.entry      (entry)
	);

	u8enc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (entry),
		.pop        (pop),
		.head       (head),
		.not_empty  (not_empty),
		.full       (full)
	);

	u8enc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.not_empty  (not_empty),
		.pop        (pop),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.out_byte   (out_byte),
		.last_byte  (last_byte)
	);

endmodule

`default_nettype wire

FILE: sim/tb_utf8_codepoint_encoder_core.sv
// ----------------------------------------------------------------------------
// tb_utf8_codepoint_encoder_core
// Self-checking bench for the UTF-8 code point encoder. A directed table walks
// the length breakpoints, the six-byte lead and out-of-range replacement.
// Random code points then run under several limit and replacement settings,
// with random idle cycles on both sides and one long byte-side hold-off.
// Every byte is checked against a directed row's typed bytes or the predictor.
// ----------------------------------------------------------------------------

module tb_utf8_codepoint_encoder_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] SIX_BYTE_TOP = 32'h8000_0000;
	localparam int          QUIET_LIMIT  = 1000;

	// One expected byte of an encoded sequence
	typedef struct packed {
		logic [7:0] val;
		logic       last;
	} utf8_byte_t;

	// Directed row: nb == 0 means the predictor supplies the bytes,
	// otherwise seq holds nb bytes right-justified, lead byte leftmost.
	typedef struct packed {
		logic [31:0] cp;
		logic [2:0]  nb;
		logic [47:0] seq;
	} code_row_t;

	// One register setting and the traffic shape run under it
	typedef struct packed {
		logic [31:0] limit;
		logic [31:0] repl;
		logic        random_cfg;
		logic [3:0]  tx_gap;
		logic [3:0]  rx_gap;
		logic [7:0]  hold;
		logic [7:0]  items;
	} cfg_phase_t;

	localparam code_row_t DIRECTED_ROWS [21] = '{
		'{32'h0000_0000, 3'd1, 48'h00},
		'{32'h0000_007F, 3'd1, 48'h7F},
		'{32'h0000_0080, 3'd2, 48'hC280},
		'{32'h0000_07FF, 3'd2, 48'hDFBF},
		'{32'h0000_0800, 3'd3, 48'hE0A080},
		'{32'h0000_FFFF, 3'd3, 48'hEFBFBF},
		'{32'h0001_0000, 3'd4, 48'hF0908080},
		'{32'h001F_FFFF, 3'd4, 48'hF7BFBFBF},
		'{32'h0020_0000, 3'd5, 48'hF888808080},
		'{32'h03FF_FFFF, 3'd5, 48'hFBBFBFBFBF},
		'{32'h0400_0000, 3'd6, 48'hFC8480808080},
		'{32'h7FFF_FFFF, 3'd6, 48'hFDBFBFBFBFBF},
		// out of range at reset: replaced by U+FFFD
		'{32'h8000_0000, 3'd3, 48'hEFBFBD},
		'{32'hFFFF_FFFF, 3'd3, 48'hEFBFBD},
		'{32'hAAAA_AAAA, 3'd3, 48'hEFBFBD},
		'{32'h0000_FFFD, 3'd0, 48'h0},
		'{32'h0000_D800, 3'd0, 48'h0},
		'{32'h1234_5678, 3'd0, 48'h0},
		'{32'h4000_0000, 3'd0, 48'h0},
		'{32'h5555_5555, 3'd0, 48'h0},
		'{32'h2AAA_AAAA, 3'd0, 48'h0}
	};

	localparam cfg_phase_t CFG_PHASES [7] = '{
		'{32'h0000_0080, 32'h0000_0000, 1'b0, 4'd12, 4'd12, 8'd0,   8'd40},
		'{32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 4'd12, 4'd0,  8'd0,   8'd30},
		'{32'hFFFF_FFFF, 32'h0000_003F, 1'b0, 4'd0,  4'd0,  8'd0,   8'd60},
		'{32'h0001_0000, 32'hFFFF_FFFF, 1'b0, 4'd0,  4'd12, 8'd0,   8'd60},
		'{32'h0000_0800, 32'h0010_FFFF, 1'b0, 4'd0,  4'd12, 8'd150, 8'd60},
		'{32'h0000_0000, 32'h0000_0000, 1'b1, 4'd12, 4'd12, 8'd0,   8'd60},
		'{32'h8000_0000, 32'h0000_FFFD, 1'b0, 4'd6,  4'd6,  8'd0,   8'd120}
	};

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [31:0] cfg_data;
	logic        code_valid;
	logic        code_stall;
	logic [31:0] code_point;
	logic        byte_valid;
	logic        byte_stall;
	logic [7:0]  out_byte;
	logic        last_byte;

	// predictor copy of the two registers
	logic [31:0] code_limit_q  = u8enc_pkg::CODE_LIMIT_RESET;
	logic [30:0] replacement_q = u8enc_pkg::REPLACEMENT_RESET;

	utf8_byte_t  utf8_bytes_q[$];
	int          mismatch_count = 0;
	int          quiet_cycles   = 0;
	int          tx_gap_max     = 3;
	int          rx_gap_max     = 3;
	int          rx_hold_cycles = 0;

	utf8_codepoint_encoder_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.code_point (code_point),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.out_byte   (out_byte),
		.last_byte  (last_byte)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Encode one accepted code point under the current registers and queue
	// its bytes, lead byte first.
	function automatic void queue_utf8_bytes(input logic [31:0] cp);
		logic [31:0] ceiling;
		logic [30:0] c;
		logic [31:0] part;
		logic [7:0]  lead;
		int          n;
		utf8_byte_t  b;
		// a limit past the six-byte range acts as the top of that range
		ceiling = (code_limit_q > SIX_BYTE_TOP) ? SIX_BYTE_TOP : code_limit_q;
		c = (cp >= ceiling) ? replacement_q : cp[30:0];
		if (c < u8enc_pkg::BREAK_2)      n = 1;
		else if (c < u8enc_pkg::BREAK_3) n = 2;
		else if (c < u8enc_pkg::BREAK_4) n = 3;
		else if (c < u8enc_pkg::BREAK_5) n = 4;
		else if (c < u8enc_pkg::BREAK_6) n = 5;
		else                             n = 6;
		// n leading ones then a zero: C0, E0, F0, F8, FC
		lead = 8'hFF << (8 - n);
		for (int k = 0; k < n; k++) begin
			part = {1'b0, c} >> (6 * (n - 1 - k));
			if (k > 0)       b.val = {2'b10, part[5:0]};
			else if (n == 1) b.val = {1'b0, part[6:0]};
			else             b.val = lead | part[7:0];
			b.last = (k == n - 1);
			utf8_bytes_q.push_back(b);
		end
	endfunction

	// Config write; only called while the encoder is drained
	task automatic write_reg(input logic idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == u8enc_pkg::REG_CODE_LIMIT) code_limit_q = data;
		else                                  replacement_q = data[30:0];
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Offer one code point after a random gap; valid stays up when gap is 0
	task automatic offer_code(input logic [31:0] cp, input logic [2:0] typed_n,
			input logic [47:0] typed_seq);
		int         gap;
		utf8_byte_t b;
		gap = $urandom_range(tx_gap_max, 0);
		@(negedge clk);
		if (gap > 0) begin
			code_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		code_valid = 1'b1;
		code_point = cp;
		do @(posedge clk); while (code_stall);
		// transaction taken: log the bytes it must produce
		if (typed_n == 3'd0) begin
			queue_utf8_bytes(cp);
		end else begin
			for (int k = 0; k < typed_n; k++) begin
				b.val  = typed_seq[8 * (typed_n - 1 - k) +: 8];
				b.last = (k == typed_n - 1);
				utf8_bytes_q.push_back(b);
			end
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		code_valid = 1'b0;
		while (utf8_bytes_q.size() != 0) @(posedge clk);
	endtask

	// Byte side: random stall before each transaction, one long hold on request
	initial begin : byte_sink
		int gap;
		byte_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(rx_gap_max, 0);
			if (rx_hold_cycles > 0) begin
				gap = rx_hold_cycles;
				rx_hold_cycles = 0;
			end
			@(negedge clk);
			if (gap > 0) begin
				byte_stall = 1'b1;
				repeat (gap) @(negedge clk);
			end
			byte_stall = 1'b0;
			do @(posedge clk); while (!byte_valid);
		end
	end

	// Compare every accepted byte with the oldest pending one
	always @(posedge clk) begin : byte_checker
		utf8_byte_t want;
		if (arst_n && byte_valid && !byte_stall) begin
			if (utf8_bytes_q.size() == 0) begin
				flag_mismatch($sformatf("byte %02h (last=%0b) with none pending",
					out_byte, last_byte));
			end else begin
				want = utf8_bytes_q.pop_front();
				if (out_byte !== want.val)
					flag_mismatch($sformatf("out_byte %02h, want %02h",
						out_byte, want.val));
				if (last_byte !== want.last)
					flag_mismatch($sformatf("last_byte %0b, want %0b on byte %02h",
						last_byte, want.last, want.val));
			end
		end
	end

	// Watchdog: too long without any transaction on any channel
	always @(posedge clk) begin
		if ((code_valid && !code_stall) || (byte_valid && !byte_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: %0d cycles without a transaction", quiet_cycles);
			$display("[utf8_codepoint_encoder_core] ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		logic [31:0] cp;
		cfg_valid  = 1'b0;
		cfg_index  = u8enc_pkg::REG_CODE_LIMIT;
		cfg_data   = 32'h0;
		code_valid = 1'b0;
		code_point = 32'h0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part under reset register values
		foreach (DIRECTED_ROWS[r])
			offer_code(DIRECTED_ROWS[r].cp, DIRECTED_ROWS[r].nb, DIRECTED_ROWS[r].seq);

		// random part, one register setting per phase
		foreach (CFG_PHASES[p]) begin
			wait_drained();
			if (CFG_PHASES[p].random_cfg) begin
				write_reg(u8enc_pkg::REG_CODE_LIMIT, $urandom_range(32'h8000_0000, 32'h80));
				write_reg(u8enc_pkg::REG_REPLACEMENT, $urandom);
			end else begin
				write_reg(u8enc_pkg::REG_CODE_LIMIT, CFG_PHASES[p].limit);
				write_reg(u8enc_pkg::REG_REPLACEMENT, CFG_PHASES[p].repl);
			end
			tx_gap_max     = CFG_PHASES[p].tx_gap;
			rx_gap_max     = CFG_PHASES[p].rx_gap;
			rx_hold_cycles = CFG_PHASES[p].hold;
			repeat (CFG_PHASES[p].items) begin
				// spread over every sequence length, raw words and the limit edge
				case ($urandom_range(7, 0))
					0:       cp = $urandom_range(32'h7F, 0);
					1:       cp = $urandom_range(32'h7FF, 32'h80);
					2:       cp = $urandom_range(32'hFFFF, 32'h800);
					3:       cp = $urandom_range(32'h1F_FFFF, 32'h1_0000);
					4:       cp = $urandom_range(32'h3FF_FFFF, 32'h20_0000);
					5:       cp = $urandom_range(32'h7FFF_FFFF, 32'h400_0000);
					6:       cp = $urandom;
					default: cp = code_limit_q + $urandom_range(2, 0) - 1;
				endcase
				offer_code(cp, 3'd0, 48'h0);
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("[utf8_codepoint_encoder_core] OK");
		else
			$display("[utf8_codepoint_encoder_core] ERROR");
		$finish;
	end

endmodule

FILE: sim.f
sv/u8enc_pkg.sv
sv/u8enc_front.sv
sv/u8enc_queue.sv
sv/u8enc_back.sv
sv/utf8_codepoint_encoder_core.sv
sim/tb_utf8_codepoint_encoder_core.sv
